// ===== design/sdpq_pkg.sv =====
// shared types and constants for the sorted descending priority queue
package sdpq_pkg;

  localparam int KEY_W = 32;
  localparam int OCC_W = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_WAIT,
    S_INS_CMP,
    S_INS_FRONT,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    status_e st;
    logic    rd_head;
    logic    rd_tail;
    logic    scan_step;
    logic    scan_place;
    logic    put_front;
    logic    pop_take;
    logic    load_out;
  } sdpq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic full;
    logic j_zero;
    logic less;
    logic out_free;
  } sdpq_stat_t;

endpackage

// ===== design/sdpq_if.sv =====
// valid/ready channel interfaces for the queue operation and result words
interface sdpq_in_if import sdpq_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [KEY_W-1:0] key_in;

  modport source (output valid, output opcode, output key_in, input ready);
  modport sink (input valid, input opcode, input key_in, output ready);
endinterface

interface sdpq_out_if import sdpq_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key_out;
  logic [1:0]              status;
  logic [OCC_W-1:0]        occupancy;

  modport source (output valid, output key_out, output status, output occupancy, input ready);
  modport sink (input valid, input key_out, input status, input occupancy, output ready);
endinterface

// ===== design/sdpq_ctrl.sv =====
// controller state machine for the priority queue
module sdpq_ctrl import sdpq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_opcode_i,
  output logic       in_ready_o,
  input  sdpq_stat_t stat_i,
  output sdpq_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_opcode_i == OP_POP) begin
            state_d = stat_i.count_zero ? S_DONE : S_POP_WAIT;
          end else if (stat_i.full) begin
            state_d = S_DONE;
          end else begin
            state_d = stat_i.count_zero ? S_INS_FRONT : S_INS_CMP;
          end
        end
      end
      S_POP_WAIT: state_d = S_DONE;
      S_INS_CMP: begin
        if (!stat_i.less) begin
          state_d = S_DONE;
        end else if (stat_i.j_zero) begin
          state_d = S_INS_FRONT;
        end
      end
      S_INS_FRONT: state_d = S_DONE;
      S_DONE: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.st   = ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (in_opcode_i == OP_POP) begin
            if (stat_i.count_zero) begin
              cmd_o.st = ST_EMPTY;
            end else begin
              cmd_o.rd_head = 1'b1;
            end
          end else if (stat_i.full) begin
            cmd_o.st = ST_FULL;
          end else if (!stat_i.count_zero) begin
            cmd_o.rd_tail = 1'b1;
          end
        end
      end
      S_POP_WAIT: cmd_o.pop_take = 1'b1;
      S_INS_CMP: begin
        cmd_o.scan_step  = stat_i.less;
        cmd_o.scan_place = !stat_i.less;
      end
      S_INS_FRONT: cmd_o.put_front = 1'b1;
      S_DONE: cmd_o.load_out = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== design/sdpq_dp.sv =====
// datapath: key memory as a ring, head and count, scan index and result register
module sdpq_dp import sdpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [KEY_W-1:0] key_in_i,
  input  sdpq_cmd_t               cmd_i,
  output sdpq_stat_t              stat_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [KEY_W-1:0] key_out_o,
  output logic [1:0]              status_o,
  output logic [OCC_W-1:0]        occupancy_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_C  = CW'(QUEUE_DEPTH);

  logic signed [KEY_W-1:0] mem_q [QUEUE_DEPTH];
  logic signed [KEY_W-1:0] rd_data_q;
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] res_key_q;
  status_e                 st_q;
  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           j_q, j_d;
  logic                    out_valid_q;
  logic signed [KEY_W-1:0] key_out_q;
  logic [1:0]              status_out_q;
  logic [OCC_W-1:0]        occ_q;

  logic                    we, re;
  logic [AW-1:0]           wa, ra;
  logic signed [KEY_W-1:0] wd;
  logic [AW-1:0]           tail_off;

  // logical position to memory address, offset below depth
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign tail_off = AW'(count_q - CW'(1));

  always_comb begin
    we = cmd_i.scan_step | cmd_i.scan_place | cmd_i.put_front;
    wa = cmd_i.put_front ? head_q : phys(head_q, j_q + AW'(1));
    wd = cmd_i.scan_step ? rd_data_q : key_q;
    re = cmd_i.rd_head | cmd_i.rd_tail | (cmd_i.scan_step && (j_q != '0));
    if (cmd_i.rd_head) begin
      ra = head_q;
    end else if (cmd_i.rd_tail) begin
      ra = phys(head_q, tail_off);
    end else begin
      ra = phys(head_q, j_q - AW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem_q[ra];
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    j_d     = j_q;
    if (cmd_i.rd_tail) begin
      j_d = tail_off;
    end else if (cmd_i.scan_step) begin
      j_d = j_q - AW'(1);
    end
    if (cmd_i.scan_place || cmd_i.put_front) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop_take) begin
      count_d = count_q - CW'(1);
      head_d  = (head_q == LAST_A) ? '0 : head_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      j_q     <= j_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q     <= key_in_i;
      st_q      <= cmd_i.st;
      res_key_q <= '0;
    end else if (cmd_i.pop_take) begin
      res_key_q <= rd_data_q;
    end
    if (cmd_i.load_out) begin
      key_out_q    <= res_key_q;
      status_out_q <= st_q;
      occ_q        <= OCC_W'(count_q);
    end
  end

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.full       = (count_q >= FULL_C);
  assign stat_o.j_zero     = (j_q == '0);
  assign stat_o.less       = (rd_data_q < key_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign key_out_o   = key_out_q;
  assign status_o    = status_out_q;
  assign occupancy_o = occ_q;

endmodule

// ===== design/sorted_descending_priority_queue.sv =====
// top level of the sorted descending priority queue
//
//   channel  dir  word                          handshake
//   in_i     in   opcode, key_in                valid/ready
//   out_o    out  key_out, status, occupancy    valid/ready
//
// one operation at a time; the key memory has one read and one write port
// pop reads the head on accept, takes it in the wait state; empty pop or full
// insert goes straight to the result; insert moves each key smaller than the
// new key one place back, one read and moved per cycle through the memory port
// reset empties the queue at once, no clearing pass; a stalled result holds
// the block in its final state until taken
module sorted_descending_priority_queue import sdpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  sdpq_in_if.sink        in_i,
  sdpq_out_if.source     out_o
);

  sdpq_cmd_t  cmd;
  sdpq_stat_t stat;

  sdpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sdpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_in_i    (in_i.key_in),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .key_out_o   (out_o.key_out),
    .status_o    (out_o.status),
    .occupancy_o (out_o.occupancy)
  );

endmodule

// ===== design/sdpq_checker.sv =====
// port-level checker for the priority queue and its bind
module sdpq_checker import sdpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [KEY_W-1:0] key_out_i,
  input logic [1:0]              status_i,
  input logic [OCC_W-1:0]        occupancy_i
);

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

  // error words carry a zero key
  a_err_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> key_out_i == '0)
    else $error("error word with nonzero key");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_EMPTY) |-> occupancy_i == '0)
    else $error("empty pop with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_FULL) |-> occupancy_i == FULL_OCC)
    else $error("full insert with wrong occupancy");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (QUEUE_DEPTH > 31) || (occupancy_i <= FULL_OCC))
    else $error("occupancy beyond depth");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(key_out_i) && $stable(status_i)
      && $stable(occupancy_i))
    else $error("stalled result word changed");

endmodule

bind sorted_descending_priority_queue sdpq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sdpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .key_out_i   (out_o.key_out),
  .status_i    (out_o.status),
  .occupancy_i (out_o.occupancy)
);
